// File: rtl/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared types, constants and helper functions of the key matrix scan decoder.
// ----------------------------------------------------------------------------
package kmsd_pkg;

   // Matrix geometry
   localparam int unsigned ROWS   = 8;
   localparam int unsigned ROW_W  = $clog2(ROWS);

   typedef logic [ROW_W-1:0] row_addr_type;

   // Fixed rows and line masks
   localparam row_addr_type GROUND_ROW = 3'd0;
   localparam row_addr_type CAPS_ROW   = 3'd4;
   localparam row_addr_type ALT_ROW    = 3'd5;
   localparam row_addr_type LAST_ROW   = 3'd7;

   localparam logic [7:0] GROUND_LINES = 8'hFC;
   localparam logic [7:0] COLUMN_LINES = 8'hC0;
   localparam logic [7:0] ALT_BIT      = 8'h20;
   localparam logic [7:0] CAPS_BIT     = 8'h08;

   // de Bruijn bit map
   localparam logic [4:0] DEBRUIJN_MUL = 5'h1D;
   localparam logic [2:0] MAP_MASK     = 3'h7;

   // Modifier offsets on the lookup index
   localparam logic [7:0] ALT_OFFSET  = 8'd64;
   localparam logic [7:0] CAPS_OFFSET = 8'd128;

   // Request modes
   localparam logic MODE_SCAN  = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   // One row of key state
   typedef struct packed {
      logic [7:0] pressed;
      logic [7:0] changed;
   } row_entry_type;

   // Memory access bundle from the sequencer to the row store
   typedef struct packed {
      logic          we;
      row_addr_type  waddr;
      row_entry_type wdata;
      row_addr_type  raddr;
   } mem_req_type;

   // Pressed bits of one row from the active-low pin samples
   function automatic logic [7:0] scan_bits(input row_addr_type row,
                                            input logic [7:0] p0,
                                            input logic [7:0] p1,
                                            input logic [7:0] gmask);
      logic [7:0] low0;
      logic [7:0] low1;
      logic [7:0] lines;
      low0  = ~p0;
      low1  = ~p1;
      lines = 8'(GROUND_LINES << (row - row_addr_type'(1)));
      if (row == GROUND_ROW) begin
         return low1 & GROUND_LINES;
      end
      return (((low1 & lines) >> 2) | (low0 & COLUMN_LINES)) & gmask;
   endfunction

   // Bit position code of a one-hot byte through the de Bruijn multiplier
   function automatic logic [2:0] debruijn_map(input logic [7:0] one);
      logic [12:0] prod;
      prod = 13'(one) * 13'(DEBRUIJN_MUL);
      return prod[7:5] & MAP_MASK;
   endfunction

endpackage

// File: rtl/kmsd_row_mem.sv
// ----------------------------------------------------------------------------
// kmsd_row_mem
// Eight-entry row store of pressed and changed bits, one write and one read
// port, registered read with write-first forwarding, per-entry valid bits.
// ----------------------------------------------------------------------------
module kmsd_row_mem (
   input  logic                   clock,
   input  logic                   reset,
   input  kmsd_pkg::mem_req_type  mem_req,
   output kmsd_pkg::row_entry_type rd_entry
);
   import kmsd_pkg::*;

   row_entry_type mem [ROWS];
   logic [ROWS-1:0] valid_ff;
   row_entry_type   rd_data_ff;
   logic            rd_hit_ff;
   logic            fwd;

   // Same-entry write and read in one cycle returns the new data
   assign fwd = mem_req.we && (mem_req.waddr == mem_req.raddr);

   // Storage array
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= fwd ? mem_req.wdata : mem[mem_req.raddr];
   end

   // Valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         rd_hit_ff <= fwd || valid_ff[mem_req.raddr];
         if (mem_req.we) begin
            valid_ff[mem_req.waddr] <= 1'b1;
         end
      end
   end

   assign rd_entry = rd_hit_ff ? rd_data_ff : '0;

endmodule

// File: rtl/key_matrix_scan_decoder.sv
// ----------------------------------------------------------------------------
// key_matrix_scan_decoder
// Keyboard matrix scanner: stores per-row pressed and changed bits and hands
// out the lowest newly pressed key, with sticky ALT and CAPS.
//
//   Channel  Ports                                    Handshake
//   request  req_mode, req_row_index, req_port*_pins  start && !busy
//   response rsp_key_found, rsp_key_index             rsp_strobe, one cycle
//
// A scan reads the row store, then writes the row back.
// A fetch reads the ALT and CAPS rows, then walks the rows with one row read per
// cycle over the row store port, and when a key is taken writes back the key row
// and then clears ALT and CAPS.
// Synchronous reset clears the row store valid bits and sets the ground mask.
// The receiver cannot stall; the response shows for one cycle only.
// ----------------------------------------------------------------------------
module key_matrix_scan_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  logic [2:0] req_row_index,
   input  logic [7:0] req_port0_pins,
   input  logic [7:0] req_port1_pins,
   output logic       rsp_strobe,
   output logic       rsp_key_found,
   output logic [7:0] rsp_key_index
);
   import kmsd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_F_ALT  = 7'b0000100,
      ST_F_CAPS = 7'b0001000,
      ST_F_WALK = 7'b0010000,
      ST_F_CLR5 = 7'b0100000,
      ST_F_CLR4 = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   row_addr_type  row_ff, row_in;
   logic [7:0]    p0_ff, p1_ff;
   logic [7:0]    gmask_ff, gmask_in;
   logic          alt_ff, alt_in;
   logic          caps_ff, caps_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [7:0]    rsp_index_ff, rsp_index_in;

   mem_req_type   mem_req;
   row_entry_type rd_entry;

   logic          accept;
   logic [7:0]    new_bits;
   logic [7:0]    cand;
   logic [7:0]    one;
   logic          skip;
   logic          take;
   logic [7:0]    base_index;

   kmsd_row_mem u_row_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   assign accept = start && (state_ff == ST_IDLE);

   // Scan datapath
   assign new_bits = scan_bits(row_ff, p0_ff, p1_ff, gmask_ff);

   // Walk datapath: lowest pressed and changed key of the row just read
   assign cand = rd_entry.pressed & rd_entry.changed;
   assign one  = cand & (~cand + 8'd1);
   assign skip = ((row_ff == ALT_ROW) && (one == ALT_BIT)) ||
                 ((row_ff == CAPS_ROW) && (one == CAPS_BIT));
   assign take = (cand != 8'd0) && !skip;
   assign base_index = {2'b00, row_ff, debruijn_map(one)};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      gmask_in      = gmask_ff;
      alt_in        = alt_ff;
      caps_in       = caps_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      mem_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in = req_row_index;
               if (req_mode == MODE_SCAN) begin
                  mem_req.raddr = req_row_index;
                  state_in      = ST_SCAN;
               end else begin
                  mem_req.raddr = ALT_ROW;
                  state_in      = ST_F_ALT;
               end
            end
         end
         ST_SCAN: begin
            mem_req.we            = 1'b1;
            mem_req.waddr         = row_ff;
            mem_req.wdata.pressed = new_bits;
            mem_req.wdata.changed = rd_entry.changed | (rd_entry.pressed ^ new_bits);
            if (row_ff == GROUND_ROW) begin
               gmask_in = ~(new_bits >> 2);
            end
            state_in = ST_IDLE;
         end
         ST_F_ALT: begin
            alt_in        = |(rd_entry.changed & ~rd_entry.pressed & ALT_BIT);
            mem_req.raddr = CAPS_ROW;
            state_in      = ST_F_CAPS;
         end
         ST_F_CAPS: begin
            caps_in       = |(rd_entry.changed & ~rd_entry.pressed & CAPS_BIT);
            row_in        = GROUND_ROW;
            mem_req.raddr = GROUND_ROW;
            state_in      = ST_F_WALK;
         end
         ST_F_WALK: begin
            if (take) begin
               mem_req.we            = 1'b1;
               mem_req.waddr         = row_ff;
               mem_req.wdata.pressed = rd_entry.pressed;
               mem_req.wdata.changed = rd_entry.changed & ~one;
               mem_req.raddr         = ALT_ROW;
               rsp_found_in          = 1'b1;
               if (alt_ff) begin
                  rsp_index_in = base_index + ALT_OFFSET;
               end else if (caps_ff) begin
                  rsp_index_in = base_index + CAPS_OFFSET;
               end else begin
                  rsp_index_in = base_index;
               end
               state_in = ST_F_CLR5;
            end else if (row_ff == LAST_ROW) begin
               rsp_found_in  = 1'b0;
               rsp_index_in  = 8'd0;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               row_in        = row_ff + row_addr_type'(1);
               mem_req.raddr = row_ff + row_addr_type'(1);
            end
         end
         ST_F_CLR5: begin
            // clear the ALT change bit, row 5 read after the key write-back
            mem_req.we            = 1'b1;
            mem_req.waddr         = ALT_ROW;
            mem_req.wdata.pressed = rd_entry.pressed;
            mem_req.wdata.changed = rd_entry.changed & ~ALT_BIT;
            mem_req.raddr         = CAPS_ROW;
            state_in              = ST_F_CLR4;
         end
         ST_F_CLR4: begin
            mem_req.we            = 1'b1;
            mem_req.waddr         = CAPS_ROW;
            mem_req.wdata.pressed = rd_entry.pressed;
            mem_req.wdata.changed = rd_entry.changed & ~CAPS_BIT;
            rsp_strobe_in         = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gmask_ff      <= 8'hFF;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gmask_ff      <= gmask_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      alt_ff       <= alt_in;
      caps_ff      <= caps_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      if (accept) begin
         p0_ff <= req_port0_pins;
         p1_ff <= req_port1_pins;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_key_found = rsp_found_ff;
   assign rsp_key_index = rsp_index_ff;

endmodule

// File: rtl/kmsd_checker.sv
// ----------------------------------------------------------------------------
// kmsd_checker
// Port-level checks of the key matrix scan decoder, bound to the top level.
// ----------------------------------------------------------------------------
module kmsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_key_found,
   input logic [7:0] rsp_key_index
);

   // An accepted transaction keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after an accepted transaction");

   // Responses are single-cycle and never back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // A response ends a transaction that was in progress
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");

   // No key means a zero index
   a_empty_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_key_found) |-> (rsp_key_index == 8'd0))
      else $error("nonzero index without a key");

   // ALT and CAPS offsets are exclusive
   a_modifier_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_key_found) |-> (rsp_key_index[7:6] != 2'b11))
      else $error("both modifier offsets on one key index");

endmodule

bind key_matrix_scan_decoder kmsd_checker u_kmsd_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_key_found (rsp_key_found),
   .rsp_key_index (rsp_key_index)
);

// File: tb/key_matrix_scan_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scan_decoder_checker
// Watches the request and response channels of the key matrix scan decoder.
// It keeps its own copy of the per-row pressed and changed bits and of the
// ground mask, and works out the key event that each fetch should return.
// Every response is compared with the oldest outstanding key event.
// ----------------------------------------------------------------------------
module key_matrix_scan_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_mode,
   input  logic [2:0]  req_row_index,
   input  logic [7:0]  req_port0_pins,
   input  logic [7:0]  req_port1_pins,
   input  logic        rsp_strobe,
   input  logic        rsp_key_found,
   input  logic [7:0]  rsp_key_index,
   output int unsigned fail_count,
   output int unsigned pending
);
   import kmsd_pkg::*;

   typedef struct packed {
      logic       found;
      logic [7:0] key_index;
   } key_event_type;

   // Shadow key state
   logic [7:0]    pressed_q [ROWS];
   logic [7:0]    changed_q [ROWS];
   logic [7:0]    gmask_q;
   key_event_type pending_keys [$];
   key_event_type want;

   // Row sample: derive pressed bits, accumulate changes
   function automatic void apply_scan(input row_addr_type row, input logic [7:0] p0,
                                      input logic [7:0] p1);
      logic [7:0] lines;
      logic [7:0] bits;
      if (row == GROUND_ROW) begin
         bits    = ~p1 & GROUND_LINES;
         gmask_q = ~(bits >> 2);
      end else begin
         lines = GROUND_LINES << (row - 1);
         bits  = (((~p1 & lines) >> 2) | (~p0 & COLUMN_LINES)) & gmask_q;
      end
      changed_q[row] = changed_q[row] | (pressed_q[row] ^ bits);
      pressed_q[row] = bits;
   endfunction

   // Lowest newly pressed key, with sticky ALT / CAPS
   function automatic key_event_type take_key();
      logic          alt_on;
      logic          caps_on;
      logic [7:0]    cand;
      logic [7:0]    one;
      logic [15:0]   prod;
      key_event_type ev;
      logic          done;
      int            r;
      alt_on  = |(changed_q[ALT_ROW] & ~pressed_q[ALT_ROW] & ALT_BIT);
      caps_on = |(changed_q[CAPS_ROW] & ~pressed_q[CAPS_ROW] & CAPS_BIT);
      ev      = '0;
      done    = 1'b0;
      for (r = 0; r < ROWS; r++) begin
         cand = pressed_q[r] & changed_q[r];
         one  = cand & (~cand + 8'd1);
         // a row whose lowest new key is a modifier is passed over entirely
         if (!done && cand != 8'd0 &&
             !((r == ALT_ROW && one == ALT_BIT) || (r == CAPS_ROW && one == CAPS_BIT))) begin
            done                = 1'b1;
            changed_q[r]        = changed_q[r] & ~one;
            changed_q[ALT_ROW]  = changed_q[ALT_ROW] & ~ALT_BIT;
            changed_q[CAPS_ROW] = changed_q[CAPS_ROW] & ~CAPS_BIT;
            prod                = 16'(one) * 16'(DEBRUIJN_MUL);
            ev.found            = 1'b1;
            ev.key_index        = 8'(r * 8) + 8'(prod[7:5]);
            if (alt_on) begin
               ev.key_index = ev.key_index + ALT_OFFSET;
            end else if (caps_on) begin
               ev.key_index = ev.key_index + CAPS_OFFSET;
            end
         end
      end
      return ev;
   endfunction

   // Compare responses first, then account for the transaction accepted at
   // this edge; a response never belongs to a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            pressed_q[i] = 8'h00;
            changed_q[i] = 8'h00;
         end
         gmask_q = 8'hFF;
         pending_keys.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_keys.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected response found=%0b index=%0d", $realtime,
                           rsp_key_found, rsp_key_index);
               end
            end else begin
               want = pending_keys.pop_front();
               if (want.found !== rsp_key_found || want.key_index !== rsp_key_index) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display({"%0t: key event mismatch: expected found=%0b index=%0d,",
                               " got found=%0b index=%0d"},
                              $realtime, want.found, want.key_index, rsp_key_found,
                              rsp_key_index);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (req_mode == MODE_SCAN) begin
               apply_scan(req_row_index, req_port0_pins, req_port1_pins);
            end else begin
               pending_keys.push_back(take_key());
            end
         end
      end
      pending = pending_keys.size();
   end

endmodule

// File: tb/tb_key_matrix_scan_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_matrix_scan_decoder
// Drives scan and fetch transactions into the key matrix scan decoder: a
// directed pass over ground masking, the column-only row, sticky ALT / CAPS
// and skipped modifier rows, then random key activity with sparse presses.
// The checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_key_matrix_scan_decoder;
   import kmsd_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [2:0]  req_row_index;
   logic [7:0]  req_port0_pins;
   logic [7:0]  req_port1_pins;
   logic        rsp_strobe;
   logic        rsp_key_found;
   logic [7:0]  rsp_key_index;
   int unsigned fail_count;
   int unsigned pending;
   logic        idle_on;
   int          wait_cycles;

   key_matrix_scan_decoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_row_index  (req_row_index),
      .req_port0_pins (req_port0_pins),
      .req_port1_pins (req_port1_pins),
      .rsp_strobe     (rsp_strobe),
      .rsp_key_found  (rsp_key_found),
      .rsp_key_index  (rsp_key_index)
   );

   key_matrix_scan_decoder_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_row_index  (req_row_index),
      .req_port0_pins (req_port0_pins),
      .req_port1_pins (req_port1_pins),
      .rsp_strobe     (rsp_strobe),
      .rsp_key_found  (rsp_key_found),
      .rsp_key_index  (rsp_key_index),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("key_matrix_scan_decoder regression: fail");
      $finish;
   end

   // Gap before a transaction: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Pin levels with only a few lines pulled low, sometimes fully random
   function automatic logic [7:0] sparse_pins();
      logic [7:0] v;
      if ($urandom_range(0, 9) == 0) begin
         return 8'($urandom);
      end
      v = 8'hFF;
      for (int b = 0; b < 8; b++) begin
         if ($urandom_range(0, 7) == 0) begin
            v[b] = 1'b0;
         end
      end
      return v;
   endfunction

   // One transaction; called and returns at a falling edge
   task automatic issue(input logic mode, input logic [2:0] row, input logic [7:0] p0,
                        input logic [7:0] p1);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_row_index  <= row;
      req_port0_pins <= p0;
      req_port1_pins <= p1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold off until every key event has come back, then let the block settle
   task automatic drain();
      start <= 1'b0;
      for (wait_cycles = 0; pending != 0 && wait_cycles < 2000; wait_cycles++) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
   endtask

   // Stimulus and verdict
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = MODE_SCAN;
      req_row_index  = 3'd0;
      req_port0_pins = 8'hFF;
      req_port1_pins = 8'hFF;
      idle_on        = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // nothing to fetch, rows before any ground scan, column-only last row
      issue(MODE_FETCH, 3'd0, 8'h00, 8'h00);
      issue(MODE_SCAN, 3'd3, 8'hFF, 8'h00);
      issue(MODE_SCAN, LAST_ROW, 8'h00, 8'h00);
      issue(MODE_FETCH, 3'd0, 8'hFF, 8'hFF);
      issue(MODE_SCAN, 3'd1, 8'h00, 8'hFF);
      // ground row fully pressed masks the driven rows
      issue(MODE_SCAN, GROUND_ROW, 8'hFF, 8'h00);
      issue(MODE_SCAN, 3'd2, 8'h00, 8'h00);
      issue(MODE_FETCH, 3'd7, 8'h00, 8'hFF);
      // release everything
      issue(MODE_SCAN, GROUND_ROW, 8'hFF, 8'hFF);
      issue(MODE_SCAN, 3'd1, 8'hFF, 8'hFF);
      issue(MODE_SCAN, 3'd2, 8'hFF, 8'hFF);
      issue(MODE_SCAN, 3'd3, 8'hFF, 8'hFF);
      issue(MODE_SCAN, LAST_ROW, 8'hFF, 8'hFF);
      // ALT alone: its row is skipped
      issue(MODE_SCAN, ALT_ROW, 8'hFF, 8'h7F);
      issue(MODE_FETCH, 3'd0, 8'h00, 8'h00);
      // ALT and CAPS both sticky: ALT wins
      issue(MODE_SCAN, ALT_ROW, 8'hFF, 8'hFF);
      issue(MODE_SCAN, CAPS_ROW, 8'hFF, 8'hDF);
      issue(MODE_SCAN, CAPS_ROW, 8'hFF, 8'hFF);
      issue(MODE_SCAN, 3'd6, 8'hFF, 8'h7F);
      issue(MODE_FETCH, 3'd0, 8'h00, 8'h00);
      // CAPS alone
      issue(MODE_SCAN, CAPS_ROW, 8'hFF, 8'hDF);
      issue(MODE_SCAN, CAPS_ROW, 8'hFF, 8'hFF);
      issue(MODE_SCAN, 3'd2, 8'h7F, 8'hFF);
      issue(MODE_FETCH, 3'd0, 8'h00, 8'h00);
      issue(MODE_FETCH, 3'd0, 8'h00, 8'h00);
      drain();

      // random key activity: sparse presses, fetches between scans
      for (int n = 0; n < 1625; n++) begin
         if (n % 150 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
         end
         if (n % 400 == 399) begin
            drain();
         end
         if ($urandom_range(0, 99) < 58) begin
            logic [2:0] row;
            logic [7:0] p1;
            row = 3'($urandom);
            if (row == GROUND_ROW) begin
               p1 = ($urandom_range(0, 4) == 0) ? sparse_pins() : 8'hFF;
            end else begin
               p1 = sparse_pins();
            end
            issue(MODE_SCAN, row, sparse_pins(), p1);
         end else begin
            issue(MODE_FETCH, 3'($urandom), 8'($urandom), 8'($urandom));
         end
      end

      // wait out the last key events
      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("key_matrix_scan_decoder regression: pass");
      end else begin
         $display("key_matrix_scan_decoder regression: fail");
      end
      $finish;
   end

endmodule

// File: key_matrix_scan_decoder.f
rtl/kmsd_pkg.sv
rtl/kmsd_row_mem.sv
rtl/key_matrix_scan_decoder.sv
rtl/kmsd_checker.sv
tb/key_matrix_scan_decoder_checker.sv
tb/tb_key_matrix_scan_decoder.sv
